// File: design/assert_macros.svh
// Assertion macros for the checker file of this project.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off during reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("concurrent assertion failed");

// Concurrent assertion on the rising clock edge that is also checked in reset.
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("concurrent assertion failed");

`endif

// File: design/fbc_pkg.sv
// Shared constants, types and register codes of the foreground bounding box block.
// No dependencies; every other file but assert_macros.svh imports this package.
`default_nettype none

package fbc_pkg;

   // Frame size limits and derived widths.
   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = 12;
   localparam int ROW_W       = 12;
   localparam int SIZE_W      = 13;
   localparam int PIX_W       = 16;
   localparam int COUNT_W     = 25;
   localparam int SUM_W       = 36;
   localparam int FRAC_W      = 8;
   localparam int CENTER_W    = 20;

   // Divider produces one quotient bit per step.
   localparam int DIV_STEPS   = CENTER_W;
   localparam int STEP_W      = 5;

   // Configuration port.
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS       = 2'd2;

   localparam logic [SIZE_W-1:0] RESET_COLUMNS = 13'd640;
   localparam logic [SIZE_W-1:0] RESET_ROWS    = 13'd480;
   localparam logic [SIZE_W-1:0] MAX_COLS_SZ   = 13'd4096;
   localparam logic [SIZE_W-1:0] MAX_ROWS_SZ   = 13'd4096;

   // Result item, last field in the lowest bits.
   typedef struct packed {
      logic [CENTER_W-1:0] center_row;
      logic [CENTER_W-1:0] center_column;
      logic [COUNT_W-1:0]  foreground_count;
      logic [ROW_W-1:0]    bottom_edge;
      logic [COL_W-1:0]    right_edge;
      logic [SIZE_W-1:0]   top_edge;
      logic [SIZE_W-1:0]   left_edge;
   } fbc_result_type;

   localparam int RESULT_W   = $bits(fbc_result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic pixel;      // a pixel transfer takes place this cycle
      logic capture;    // that pixel closes the frame: snapshot the totals
      logic div_step;   // one restoring division step on both centroids
      logic load_out;   // move the finished result into the output register
   } fbc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_pixel; // the next pixel is the last one of the frame
   } fbc_sts_type;

endpackage

`default_nettype wire

// File: design/foreground_bbox_centroid.sv
// Top level of the foreground bounding box and centroid block.
// Depends on fbc_pkg, fbc_ctrl and fbc_datapath.
//
//   Channel  Direction  Handshake                Payload
//   req_     in         req_tvalid/req_tready    req_tdata[15:0]: pixel_value
//   rsp_     out        rsp_tvalid/rsp_tready    rsp_tdata[119:0]: one result per frame
//   csr_     in         csr_valid/csr_ready      csr_index[1:0], csr_data[15:0]
//
// One pixel is taken per cycle while req_tready is high. The last pixel of a
// frame starts the centroid divider, which gives one quotient bit per cycle.
// Pixels of the next frame are taken meanwhile; only its last pixel waits until
// the divider has handed its result to the output register. Reset is
// synchronous and restores 640 x 480 with background 0. A stalled result holds
// the output register and, through it, the divider.
`default_nettype none

module foreground_bbox_centroid
   import fbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pixel_value [15:0]
   input  wire logic [PIX_W-1:0]      req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // left_edge [12:0], top_edge [25:13], right_edge [37:26], bottom_edge [49:38],
   // foreground_count [74:50], center_column [94:75], center_row [114:95], zeros
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   fbc_cmd_type    cmd;
   fbc_sts_type    sts;
   fbc_result_type result;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   fbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fbc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .pixel_value (req_tdata),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .result      (result)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire

// File: design/fbc_ctrl.sv
// Controller of the foreground bounding box block: input gating, division
// sequencing and output valid. Depends on fbc_pkg.
`default_nettype none

module fbc_ctrl
   import fbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire fbc_sts_type sts,
   output fbc_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   // A frame-closing pixel waits until the divider has finished the last frame.
   assign req_tready = !(sts.last_pixel && (state_ff != ST_IDLE));
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.pixel    = accept;
      cmd.capture  = accept && sts.last_pixel;
      cmd.div_step = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_DIVIDE;
               step_in  = '0;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared by a transfer.
   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: design/fbc_datapath.sv
// Datapath of the foreground bounding box block: configuration registers,
// raster position, running totals, centroid divider and output register.
// Depends on fbc_pkg.
`default_nettype none

module fbc_datapath
   import fbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [PIX_W-1:0]      pixel_value,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire fbc_cmd_type           cmd,
   output fbc_sts_type                sts,
   output fbc_result_type             result
);

   // Configuration.
   logic [PIX_W-1:0]  background_ff, background_in;
   logic [SIZE_W-1:0] columns_ff, columns_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [SIZE_W-1:0] csr_size;
   logic              size_write;

   // Raster position and running totals.
   logic [COL_W-1:0]   col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]   row_pos_ff, row_pos_in;
   logic [SIZE_W-1:0]  left_ff, left_in, left_acc;
   logic [SIZE_W-1:0]  top_ff, top_in, top_acc;
   logic [COL_W-1:0]   right_ff, right_in, right_acc;
   logic [ROW_W-1:0]   bottom_ff, bottom_in, bottom_acc;
   logic [COUNT_W-1:0] count_ff, count_in, count_acc;
   logic [SUM_W-1:0]   col_sum_ff, col_sum_in, col_sum_acc;
   logic [SUM_W-1:0]   row_sum_ff, row_sum_in, row_sum_acc;
   logic               foreground;
   logic               col_last;
   logic               row_last;

   // Frame snapshot and divider.
   logic [SIZE_W-1:0]   snap_left_ff, snap_top_ff;
   logic [COL_W-1:0]    snap_right_ff;
   logic [ROW_W-1:0]    snap_bottom_ff;
   logic [COUNT_W-1:0]  divisor_ff;
   logic [COUNT_W-1:0]  rem_col_ff, rem_col_in, rem_row_ff, rem_row_in;
   logic [CENTER_W-1:0] quo_col_ff, quo_col_in, quo_row_ff, quo_row_in;
   logic [COUNT_W+1:0]  trial_col, trial_row;

   fbc_result_type out_ff;

   // Register writes; a size outside 1..max is stored already clamped.
   always_comb begin
      priority if (csr_data[SIZE_W-1:0] == '0) begin
         csr_size = SIZE_W'(1);
      end else if (csr_data[SIZE_W-1:0] > MAX_COLS_SZ) begin
         csr_size = MAX_COLS_SZ;
      end else begin
         csr_size = csr_data[SIZE_W-1:0];
      end
   end

   always_comb begin
      background_in = background_ff;
      columns_in    = columns_ff;
      rows_in       = rows_ff;
      size_write    = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_BACKGROUND: background_in = csr_data;
            REG_COLUMNS: begin
               columns_in = csr_size;
               size_write = 1'b1;
            end
            REG_ROWS: begin
               rows_in    = (csr_size > MAX_ROWS_SZ) ? MAX_ROWS_SZ : csr_size;
               size_write = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Position within the frame.
   assign col_last       = ({1'b0, col_pos_ff} == columns_ff - SIZE_W'(1));
   assign row_last       = ({1'b0, row_pos_ff} == rows_ff - SIZE_W'(1));
   assign sts.last_pixel = col_last && row_last;
   assign foreground     = (pixel_value != background_ff);

   // Totals including the current pixel.
   always_comb begin
      left_acc    = left_ff;
      top_acc     = top_ff;
      right_acc   = right_ff;
      bottom_acc  = bottom_ff;
      count_acc   = count_ff;
      col_sum_acc = col_sum_ff;
      row_sum_acc = row_sum_ff;
      if (foreground) begin
         count_acc   = count_ff + COUNT_W'(1);
         col_sum_acc = col_sum_ff + SUM_W'(col_pos_ff);
         row_sum_acc = row_sum_ff + SUM_W'(row_pos_ff);
         if ({1'b0, col_pos_ff} < left_ff) left_acc = {1'b0, col_pos_ff};
         if ({1'b0, row_pos_ff} < top_ff)  top_acc  = {1'b0, row_pos_ff};
         if (col_pos_ff > right_ff)        right_acc = col_pos_ff;
         bottom_acc = row_pos_ff;
      end
   end

   // Next running state: a size write or a closed frame starts a new frame.
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      left_in    = left_ff;
      top_in     = top_ff;
      right_in   = right_ff;
      bottom_in  = bottom_ff;
      count_in   = count_ff;
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      priority if (size_write || cmd.capture) begin
         col_pos_in = '0;
         row_pos_in = '0;
         left_in    = columns_in;
         top_in     = rows_in;
         right_in   = '0;
         bottom_in  = '0;
         count_in   = '0;
         col_sum_in = '0;
         row_sum_in = '0;
      end else if (cmd.pixel) begin
         left_in    = left_acc;
         top_in     = top_acc;
         right_in   = right_acc;
         bottom_in  = bottom_acc;
         count_in   = count_acc;
         col_sum_in = col_sum_acc;
         row_sum_in = row_sum_acc;
         if (col_last) begin
            col_pos_in = '0;
            row_pos_in = row_pos_ff + ROW_W'(1);
         end else begin
            col_pos_in = col_pos_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         background_ff <= '0;
         columns_ff    <= RESET_COLUMNS;
         rows_ff       <= RESET_ROWS;
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         left_ff       <= RESET_COLUMNS;
         top_ff        <= RESET_ROWS;
         right_ff      <= '0;
         bottom_ff     <= '0;
         count_ff      <= '0;
         col_sum_ff    <= '0;
         row_sum_ff    <= '0;
      end else begin
         background_ff <= background_in;
         columns_ff    <= columns_in;
         rows_ff       <= rows_in;
         col_pos_ff    <= col_pos_in;
         row_pos_ff    <= row_pos_in;
         left_ff       <= left_in;
         top_ff        <= top_in;
         right_ff      <= right_in;
         bottom_ff     <= bottom_in;
         count_ff      <= count_in;
         col_sum_ff    <= col_sum_in;
         row_sum_ff    <= row_sum_in;
      end
   end

   // Restoring division of (sum << 8) by the count, one quotient bit per step.
   // The mean position is below 4096, so the upper dividend bits start below
   // the divisor and twenty steps give the whole quotient.
   assign trial_col = {1'b0, rem_col_ff, quo_col_ff[CENTER_W-1]} - {2'b00, divisor_ff};
   assign trial_row = {1'b0, rem_row_ff, quo_row_ff[CENTER_W-1]} - {2'b00, divisor_ff};

   always_comb begin
      rem_col_in = rem_col_ff;
      quo_col_in = quo_col_ff;
      rem_row_in = rem_row_ff;
      quo_row_in = quo_row_ff;
      priority if (cmd.capture) begin
         rem_col_in = COUNT_W'(col_sum_acc[SUM_W-1:COL_W]);
         quo_col_in = {col_sum_acc[COL_W-1:0], {FRAC_W{1'b0}}};
         rem_row_in = COUNT_W'(row_sum_acc[SUM_W-1:ROW_W]);
         quo_row_in = {row_sum_acc[ROW_W-1:0], {FRAC_W{1'b0}}};
      end else if (cmd.div_step) begin
         if (!trial_col[COUNT_W+1]) begin
            rem_col_in = trial_col[COUNT_W-1:0];
            quo_col_in = {quo_col_ff[CENTER_W-2:0], 1'b1};
         end else begin
            rem_col_in = {rem_col_ff[COUNT_W-2:0], quo_col_ff[CENTER_W-1]};
            quo_col_in = {quo_col_ff[CENTER_W-2:0], 1'b0};
         end
         if (!trial_row[COUNT_W+1]) begin
            rem_row_in = trial_row[COUNT_W-1:0];
            quo_row_in = {quo_row_ff[CENTER_W-2:0], 1'b1};
         end else begin
            rem_row_in = {rem_row_ff[COUNT_W-2:0], quo_row_ff[CENTER_W-1]};
            quo_row_in = {quo_row_ff[CENTER_W-2:0], 1'b0};
         end
      end
   end

   // Snapshot, divider and output payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         snap_left_ff   <= left_acc;
         snap_top_ff    <= top_acc;
         snap_right_ff  <= right_acc;
         snap_bottom_ff <= bottom_acc;
         divisor_ff     <= count_acc;
      end
      rem_col_ff <= rem_col_in;
      quo_col_ff <= quo_col_in;
      rem_row_ff <= rem_row_in;
      quo_row_ff <= quo_row_in;
      if (cmd.load_out) begin
         out_ff.left_edge        <= snap_left_ff;
         out_ff.top_edge         <= snap_top_ff;
         out_ff.right_edge       <= snap_right_ff;
         out_ff.bottom_edge      <= snap_bottom_ff;
         out_ff.foreground_count <= divisor_ff;
         // With no foreground the centroid reads zero.
         out_ff.center_column    <= (divisor_ff == '0) ? '0 : quo_col_ff;
         out_ff.center_row       <= (divisor_ff == '0) ? '0 : quo_row_ff;
      end
   end

   assign result = out_ff;

endmodule

`default_nettype wire

// File: design/fbc_checker.sv
// Port-level assertions for the foreground bounding box block, with its bind.
// Depends on fbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fbc_checker
   import fbc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   fbc_result_type   res;
   logic             empty;
   logic [COL_W-1:0] center_col_whole;
   logic [ROW_W-1:0] center_row_whole;
   logic             empty_clean;
   logic             box_ordered;
   logic             center_inside;

   assign res   = rsp_tdata[RESULT_W-1:0];
   assign empty = (res.foreground_count == '0);

   // Whole-pixel part of the centroid and the conditions checked on a result.
   assign center_col_whole = res.center_column[CENTER_W-1:FRAC_W];
   assign center_row_whole = res.center_row[CENTER_W-1:FRAC_W];
   assign empty_clean   = (res.center_column == '0) && (res.center_row == '0) &&
                          (res.right_edge == '0) && (res.bottom_edge == '0);
   assign box_ordered   = (res.left_edge <= SIZE_W'(res.right_edge)) &&
                          (res.top_edge <= SIZE_W'(res.bottom_edge));
   assign center_inside = (SIZE_W'(center_col_whole) >= res.left_edge) &&
                          (center_col_whole <= res.right_edge) &&
                          (SIZE_W'(center_row_whole) >= res.top_edge) &&
                          (center_row_whole <= res.bottom_edge);

   // A stalled result holds.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // An empty frame reports a zero centroid and zero far edges.
   `ASSERT_CLK(a_empty_frame, clock, reset, rsp_tvalid && empty |-> empty_clean)

   // The box of a non-empty frame is ordered.
   `ASSERT_CLK(a_box_order, clock, reset, rsp_tvalid && !empty |-> box_ordered)

   // The centroid of a non-empty frame lies inside the box.
   `ASSERT_CLK(a_center_in_box, clock, reset, rsp_tvalid && !empty |-> center_inside)

endmodule

bind foreground_bbox_centroid fbc_checker u_fbc_checker (.*);

`default_nettype wire

// File: tb/sv/foreground_bbox_centroid_tb.sv
// Self-checking testbench for the foreground bounding box and centroid block.
// Depends on fbc_pkg and foreground_bbox_centroid. It sends pixel frames, register writes and
// random output stalls, and checks every frame result against a model of the block kept here.
module foreground_bbox_centroid_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbc_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 550;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int MAX_REPORTS = 50;
   localparam longint unsigned SUM_MASK = 64'hF_FFFF_FFFF;
   localparam int unsigned COUNT_MASK = 32'h1FF_FFFF;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   // One row of the directed stimulus; a typed result overrides the predicted one.
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [PIX_W-1:0]     value;
      logic                 typed;
      fbc_result_type       result;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [PIX_W-1:0]      req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Model copy of the registers and of the per-frame accumulators.
   logic [PIX_W-1:0]  bg_value;
   logic [SIZE_W-1:0] cols_setting;
   logic [SIZE_W-1:0] rows_setting;
   int unsigned       col_at, row_at;
   int unsigned       box_left, box_top, box_right, box_bottom, fg_count;
   longint unsigned   sum_cols, sum_rows;

   fbc_result_type pending_boxes[$];
   script_row_type script_rows[$];
   bit             sender_idle = 1'b0;
   int             mismatch_count = 0;
   int             random_items = 0;
   int unsigned    cycle_count = 0;

   foreground_bbox_centroid i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("foreground_bbox_centroid_tb NOT OK");
         $finish;
      end
   end

   // Effective frame dimension: zero reads as one, anything above the maximum as the maximum.
   function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v,
                                             input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void restart_frame();
      col_at = 0;
      row_at = 0;
      box_left = clamp_dim(cols_setting, MAX_COLUMNS);
      box_top = clamp_dim(rows_setting, MAX_ROWS);
      box_right = 0;
      box_bottom = 0;
      fg_count = 0;
      sum_cols = 0;
      sum_rows = 0;
   endfunction

   // A size write throws away the frame in progress; a background write does not.
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_BACKGROUND: bg_value = data;
         REG_COLUMNS: begin
            cols_setting = data[SIZE_W-1:0];
            restart_frame();
         end
         REG_ROWS: begin
            rows_setting = data[SIZE_W-1:0];
            restart_frame();
         end
         default: ;
      endcase
   endfunction

   // Folds one pixel into the running box; returns 1 with the result when it closes a frame.
   function automatic bit fold_pixel(input logic [PIX_W-1:0] pix, output fbc_result_type box);
      int unsigned cols, rows;
      cols = clamp_dim(cols_setting, MAX_COLUMNS);
      rows = clamp_dim(rows_setting, MAX_ROWS);
      box = '0;
      if (pix != bg_value) begin
         fg_count = (fg_count + 1) & COUNT_MASK;
         sum_cols = (sum_cols + col_at) & SUM_MASK;
         sum_rows = (sum_rows + row_at) & SUM_MASK;
         if (col_at < box_left) box_left = col_at;
         if (row_at < box_top) box_top = row_at;
         if (col_at > box_right) box_right = col_at;
         box_bottom = row_at;
      end
      if (col_at + 1 < cols) begin
         col_at++;
         return 1'b0;
      end
      col_at = 0;
      if (row_at + 1 < rows) begin
         row_at++;
         return 1'b0;
      end
      // With no foreground the box collapses to the frame size and no division is made.
      if (fg_count == 0) begin
         box.left_edge = SIZE_W'(cols);
         box.top_edge = SIZE_W'(rows);
      end else begin
         box.left_edge = SIZE_W'(box_left);
         box.top_edge = SIZE_W'(box_top);
         box.right_edge = COL_W'(box_right);
         box.bottom_edge = ROW_W'(box_bottom);
         box.center_column = CENTER_W'((sum_cols << FRAC_W) / fg_count);
         box.center_row = CENTER_W'((sum_rows << FRAC_W) / fg_count);
      end
      box.foreground_count = COUNT_W'(fg_count);
      restart_frame();
      return 1'b1;
   endfunction

   function automatic fbc_result_type make_box(input int unsigned l, t, r, b, n, cc, cr);
      fbc_result_type box;
      box.left_edge = SIZE_W'(l);
      box.top_edge = SIZE_W'(t);
      box.right_edge = COL_W'(r);
      box.bottom_edge = ROW_W'(b);
      box.foreground_count = COUNT_W'(n);
      box.center_column = CENTER_W'(cc);
      box.center_row = CENTER_W'(cr);
      return box;
   endfunction

   function automatic void add_pixel(input logic [PIX_W-1:0] v, input logic typed,
                                     input fbc_result_type box);
      script_row_type r;
      r = '0;
      r.kind = ROW_PIXEL;
      r.value = v;
      r.typed = typed;
      r.result = box;
      script_rows.push_back(r);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [PIX_W-1:0] v);
      script_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.value = v;
      script_rows.push_back(r);
   endfunction

   // Mostly background, some random values and some one bit away from the background.
   function automatic logic [PIX_W-1:0] next_pixel();
      case ($urandom_range(0, 3))
         0, 1: return bg_value;
         2: return PIX_W'($urandom);
         default: return bg_value ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
      endcase
   endfunction

   // One pixel transfer, after an optional gap; the model runs on acceptance.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                             input fbc_result_type typed_box);
      int gap;
      fbc_result_type box;
      gap = sender_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      if (fold_pixel(pix, box)) pending_boxes.push_back(typed ? typed_box : box);
   endtask

   // Register writes wait until every result is out and the divider has had time to finish.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(idx, data);
   endtask

   task automatic compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Result side: either ready ahead of time, or held off for a while once a result shows up.
   initial begin : result_sink
      int stall;
      fbc_result_type seen, want;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 1) == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            stall = $urandom_range(0, 15);
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_tvalid);
         seen = fbc_result_type'(rsp_tdata[RESULT_W-1:0]);
         if (pending_boxes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
         end else begin
            want = pending_boxes.pop_front();
            compare_field("left_edge", want.left_edge, seen.left_edge);
            compare_field("top_edge", want.top_edge, seen.top_edge);
            compare_field("right_edge", want.right_edge, seen.right_edge);
            compare_field("bottom_edge", want.bottom_edge, seen.bottom_edge);
            compare_field("foreground_count", want.foreground_count, seen.foreground_count);
            compare_field("center_column", want.center_column, seen.center_column);
            compare_field("center_row", want.center_row, seen.center_row);
         end
      end
   end

   initial begin : stimulus
      script_row_type row;
      int frame_len, total;

      bg_value = '0;
      cols_setting = RESET_COLUMNS;
      rows_setting = RESET_ROWS;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A short partial frame at the reset size; the size writes below abandon it.
      sender_idle = 1'b0;
      repeat (16) send_pixel(next_pixel(), 1'b0, '0);

      // Directed rows: empty frame, full-range pixels, a one-pixel frame, size written
      // mid-frame, background written mid-frame and a write to an unused index.
      add_write(REG_COLUMNS, 16'd3);
      add_write(REG_ROWS, 16'd2);
      repeat (5) add_pixel(16'h0000, 1'b0, '0);
      add_pixel(16'h0000, 1'b1, make_box(3, 2, 0, 0, 0, 0, 0));
      add_write(REG_BACKGROUND, 16'hFFFF);
      add_pixel(16'h0000, 1'b0, '0);
      repeat (4) add_pixel(16'hFFFF, 1'b0, '0);
      add_pixel(16'h0000, 1'b1, make_box(0, 0, 2, 1, 2, 256, 128));
      add_write(REG_COLUMNS, 16'd0);
      add_write(REG_ROWS, 16'd1);
      add_pixel(16'h8000, 1'b1, make_box(0, 0, 0, 0, 1, 0, 0));
      add_pixel(16'hFFFF, 1'b1, make_box(1, 1, 0, 0, 0, 0, 0));
      add_write(REG_COLUMNS, 16'd4);
      add_pixel(16'h0001, 1'b0, '0);
      add_pixel(16'h0002, 1'b0, '0);
      add_write(REG_COLUMNS, 16'd4);
      add_pixel(16'hFFFF, 1'b0, '0);
      add_pixel(16'h0007, 1'b0, '0);
      add_pixel(16'hFFFF, 1'b0, '0);
      add_pixel(16'hFFFF, 1'b1, make_box(1, 0, 1, 0, 1, 256, 0));
      add_pixel(16'h0005, 1'b0, '0);
      add_write(REG_UNUSED, 16'h1234);
      add_write(REG_BACKGROUND, 16'h0005);
      add_pixel(16'h0005, 1'b0, '0);
      add_pixel(16'hFFFF, 1'b0, '0);
      add_pixel(16'h0005, 1'b0, '0);

      foreach (script_rows[k]) begin
         row = script_rows[k];
         sender_idle = ($urandom_range(0, 1) == 1);
         if (row.kind == ROW_WRITE) write_register(row.index, row.value);
         else send_pixel(row.value, row.typed, row.result);
      end

      // Random phases of small frames, now and then ending on a partial frame.
      while (random_items < RANDOM_ITEMS) begin
         sender_idle = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0)
            write_register(REG_BACKGROUND,
                           ($urandom_range(0, 3) == 0) ? 16'hFFFF : CSR_DATA_W'($urandom));
         if ($urandom_range(0, 1) == 0)
            write_register(REG_COLUMNS, {3'($urandom), 13'($urandom_range(0, 6))});
         if ($urandom_range(0, 1) == 0)
            write_register(REG_ROWS, {3'($urandom), 13'($urandom_range(0, 5))});
         if ($urandom_range(0, 7) == 0)
            write_register(REG_UNUSED, CSR_DATA_W'($urandom));
         frame_len = clamp_dim(cols_setting, MAX_COLUMNS) * clamp_dim(rows_setting, MAX_ROWS);
         total = $urandom_range(1, 4) * frame_len;
         if ($urandom_range(0, 3) == 0) total += $urandom_range(1, frame_len);
         repeat (total) begin
            send_pixel(next_pixel(), 1'b0, '0);
            random_items++;
         end
      end

      // Drain and report.
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("foreground_bbox_centroid_tb OK");
      else
         $display("foreground_bbox_centroid_tb NOT OK");
      $finish;
   end

endmodule
